[src/hsm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_pkg: shared types and constants for histogram specification
// Widths, command codes and controller states.
// ----------------------------------------------------------------------------
package hsm_pkg;
    localparam int PIXEL_BITS = 8;
    localparam int COUNT_BITS = 24;
    localparam int LEVELS     = 1 << PIXEL_BITS;
    localparam int CUM_BITS   = COUNT_BITS + PIXEL_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [CUM_BITS-1:0]   cum_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SRC   = 2'd1,
        CMD_REF   = 2'd2,
        CMD_MAP   = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_MIN,
        ST_RCUM,
        ST_SCAN,
        ST_MUL,
        ST_CMP,
        ST_MAP_RD,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

[src/hsm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_if: valid/ready channel
// Carries one item per transfer.
// ----------------------------------------------------------------------------
interface hsm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] pixel_value;
    modport source (output valid, command, pixel_value, input ready);
    modport sink   (input valid, command, pixel_value, output ready);
endinterface

interface hsm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mapped_value;
    modport source (output valid, mapped_value, input ready);
    modport sink   (input valid, mapped_value, output ready);
endinterface
`default_nettype wire

[src/hsm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module hsm_ram #(
    parameter int WIDTH = 24,
    parameter int ABITS = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [1 << ABITS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[src/histogram_specification_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_specification_top: histogram matching of grey levels
// Counts source and reference histograms, builds a lookup table, maps pixels.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_ch     sink       command, pixel_value
// out_ch    source     mapped_value
//
// Count: a read, modify and write of one histogram RAM word per pixel.
// Clear: a sweep of both histogram RAMs, one word a cycle.
// Map: a read of the table RAM (MAP_RD, OUT); the first map after a clear first
//   builds the table: a minimum search and a reference cumulation sweep, then
//   a search over the reference bins (MUL, CMP per bin) for each source value.
// Reset: the histogram RAMs are swept to zero after reset, during which
//   no item is taken. A stalled result holds the block.
// ----------------------------------------------------------------------------
module histogram_specification_top
    import hsm_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    hsm_in_if.sink     in_ch,
    hsm_out_if.source  out_ch
);
    state_t state_reg, state_next;
    logic [PIXEL_BITS:0] idx_reg, idx_next;   // sweep index (one extra bit)
    logic [PIXEL_BITS:0] ridx_reg, ridx_next;
    cmd_t  cmd_reg, cmd_next;
    pix_t  pix_reg, pix_next;
    cnt_t  stot_reg, stot_next, rtot_reg, rtot_next;
    logic  ready_tbl_reg, ready_tbl_next;
    logic [PIXEL_BITS:0] smin_reg, smin_next, rmin_reg, rmin_next;
    pix_t  last_reg, last_next;
    cnt_t  smin_cnt_reg, smin_cnt_next, rmin_cnt_reg, rmin_cnt_next;
    cum_t  acc_reg, acc_next, sacc_reg, sacc_next;
    cnt_t  sden_reg, sden_next, rden_reg, rden_next;
    cum_t  scum_reg, scum_next;
    logic [2*COUNT_BITS-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic [7:0] out_reg, out_next;
    logic  ovalid_reg, ovalid_next;

    // memories
    logic sh_we, rh_we, rc_we, tb_we;
    pix_t sh_a, rh_a, rc_a, tb_a;
    cnt_t sh_wd, rh_wd, sh_rd, rh_rd;
    cnt_t rc_wd, rc_rd;
    pix_t tb_wd, tb_rd;

    hsm_ram #(.WIDTH(COUNT_BITS), .ABITS(PIXEL_BITS)) u_sh
        (.clk(clk), .we(sh_we), .addr(sh_a), .wdata(sh_wd), .rdata(sh_rd));
    hsm_ram #(.WIDTH(COUNT_BITS), .ABITS(PIXEL_BITS)) u_rh
        (.clk(clk), .we(rh_we), .addr(rh_a), .wdata(rh_wd), .rdata(rh_rd));
    hsm_ram #(.WIDTH(COUNT_BITS), .ABITS(PIXEL_BITS)) u_rc
        (.clk(clk), .we(rc_we), .addr(rc_a), .wdata(rc_wd), .rdata(rc_rd));
    hsm_ram #(.WIDTH(PIXEL_BITS), .ABITS(PIXEL_BITS)) u_tb
        (.clk(clk), .we(tb_we), .addr(tb_a), .wdata(tb_wd), .rdata(tb_rd));

    localparam logic [PIXEL_BITS:0] LV = (PIXEL_BITS+1)'(LEVELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            ready_tbl_reg <= 1'b0;
            ovalid_reg    <= 1'b0;
            stot_reg      <= '0;
            rtot_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ready_tbl_reg <= ready_tbl_next;
            ovalid_reg    <= ovalid_next;
            stot_reg      <= stot_next;
            rtot_reg      <= rtot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;   cmd_reg <= cmd_next;   pix_reg <= pix_next;
        smin_reg <= smin_next;   rmin_reg <= rmin_next; last_reg <= last_next;
        smin_cnt_reg <= smin_cnt_next; rmin_cnt_reg <= rmin_cnt_next;
        acc_reg <= acc_next;     sacc_reg <= sacc_next;
        sden_reg <= sden_next;   rden_reg <= rden_next; scum_reg <= scum_next;
        lhs_reg <= lhs_next;     rhs_reg <= rhs_next;   out_reg <= out_next;
    end

    cum_t acc_sum, sacc_sum;
    assign acc_sum  = acc_reg + CUM_BITS'(rh_rd);
    assign sacc_sum = sacc_reg + CUM_BITS'(sh_rd);

    always_comb
    begin
        state_next = state_reg;   idx_next = idx_reg;   ridx_next = ridx_reg;
        cmd_next = cmd_reg;       pix_next = pix_reg;
        stot_next = stot_reg;     rtot_next = rtot_reg;
        ready_tbl_next = ready_tbl_reg;
        smin_next = smin_reg;     rmin_next = rmin_reg; last_next = last_reg;
        smin_cnt_next = smin_cnt_reg; rmin_cnt_next = rmin_cnt_reg;
        acc_next = acc_reg;       sacc_next = sacc_reg;
        sden_next = sden_reg;     rden_next = rden_reg; scum_next = scum_reg;
        lhs_next = lhs_reg;       rhs_next = rhs_reg;
        out_next = out_reg;       ovalid_next = ovalid_reg;
        sh_we = 1'b0; rh_we = 1'b0; rc_we = 1'b0; tb_we = 1'b0;
        sh_a = pix_reg; rh_a = pix_reg; rc_a = pix_reg; tb_a = pix_reg;
        sh_wd = '0; rh_wd = '0; rc_wd = '0; tb_wd = '0;
        in_ch.ready = 1'b0;

        if (out_ch.valid && out_ch.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = !ovalid_reg;
                if (in_ch.valid && !ovalid_reg)
                begin
                    cmd_next = cmd_t'(in_ch.command);
                    pix_next = in_ch.pixel_value[PIXEL_BITS-1:0];
                    unique case (cmd_t'(in_ch.command))
                        CMD_CLEAR:
                        begin
                            idx_next = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_SRC, CMD_REF: state_next = ST_CNT_RD;
                        CMD_MAP:
                        begin
                            if (ready_tbl_reg)
                                state_next = ST_MAP_RD;
                            else
                            begin
                                // min search + reference cumulation sweep
                                idx_next = '0;
                                smin_next = LV; rmin_next = LV;
                                acc_next = '0;
                                state_next = ST_MIN;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                sh_we = 1'b1; rh_we = 1'b1;
                sh_a = idx_reg[PIXEL_BITS-1:0]; rh_a = idx_reg[PIXEL_BITS-1:0];
                stot_next = '0; rtot_next = '0; ready_tbl_next = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LV - 1'b1)
                    state_next = ST_IDLE;
            end
            ST_CNT_RD: state_next = ST_CNT_WR;
            ST_CNT_WR:
            begin
                if (cmd_reg == CMD_SRC)
                begin
                    sh_we = 1'b1;
                    sh_wd = (sh_rd == COUNT_MAX) ? sh_rd : sh_rd + 1'b1;
                    if (stot_reg != COUNT_MAX) stot_next = stot_reg + 1'b1;
                end
                else
                begin
                    rh_we = 1'b1;
                    rh_wd = (rh_rd == COUNT_MAX) ? rh_rd : rh_rd + 1'b1;
                    if (rtot_reg != COUNT_MAX) rtot_next = rtot_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_MIN:
            begin
                // read address idx, data of idx-1 arrives now
                sh_a = idx_reg[PIXEL_BITS-1:0]; rh_a = idx_reg[PIXEL_BITS-1:0];
                if (idx_reg != '0)
                begin
                    if (smin_reg == LV && sh_rd != '0)
                    begin
                        smin_next = idx_reg - 1'b1; smin_cnt_next = sh_rd;
                    end
                    if (rmin_reg == LV && rh_rd != '0)
                    begin
                        rmin_next = idx_reg - 1'b1; rmin_cnt_next = rh_rd;
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LV)
                begin
                    idx_next = '0;
                    state_next = ST_RCUM;
                end
            end
            ST_RCUM:
            begin
                // set denominators, then cumulate reference into rc RAM
                rden_next = (rmin_reg != LV && rtot_reg > rmin_cnt_reg)
                            ? rtot_reg - rmin_cnt_reg : '0;
                sden_next = (smin_reg != LV && stot_reg > smin_cnt_reg)
                            ? stot_reg - smin_cnt_reg : '0;
                rh_a = idx_reg[PIXEL_BITS-1:0];
                last_next = rmin_reg[PIXEL_BITS-1:0];
                if (idx_reg != '0)
                begin
                    if ((PIXEL_BITS+1)'(idx_reg - 1'b1) > rmin_reg && rh_rd != '0)
                    begin
                        acc_next = acc_sum;
                        last_next = pix_t'(idx_reg - 1'b1);
                    end
                    else
                        last_next = last_reg;
                    if (idx_reg == 1) last_next = rmin_reg[PIXEL_BITS-1:0];
                    rc_we = 1'b1;
                    rc_a = pix_t'(idx_reg - 1'b1);
                    rc_wd = (acc_next > CUM_BITS'(rden_next))
                            ? rden_next : cnt_t'(acc_next);
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LV)
                begin
                    idx_next = '0;
                    sacc_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // idx: source value v. Read sh[v] to update cumulative.
                sh_a = idx_reg[PIXEL_BITS-1:0];
                rh_a = rmin_reg[PIXEL_BITS-1:0];
                rc_a = rmin_reg[PIXEL_BITS-1:0];
                ridx_next = rmin_reg;
                if (rmin_reg == LV)
                begin
                    tb_we = 1'b1; tb_a = idx_reg[PIXEL_BITS-1:0]; tb_wd = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LV - 1'b1)
                    begin
                        ready_tbl_next = 1'b1;
                        state_next = ST_MAP_RD;
                    end
                end
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // rh[r], rc[r] valid now; sh[v] valid on the first bin only
                if (ridx_reg == rmin_reg)
                begin
                    if (smin_reg != LV && idx_reg > smin_reg)
                        sacc_next = sacc_sum;
                    scum_next = (sacc_next > CUM_BITS'(sden_reg))
                                ? CUM_BITS'(sden_reg) : sacc_next;
                end
                // scum never exceeds sden, so it fits a count word
                lhs_next = (2*COUNT_BITS)'(rc_rd) * (2*COUNT_BITS)'(sden_reg);
                rhs_next = (2*COUNT_BITS)'(cnt_t'(scum_next))
                           * (2*COUNT_BITS)'(rden_reg);
                if (ridx_reg != rmin_reg && rh_rd == '0)
                begin
                    // absent bin: skip
                    lhs_next = '0; rhs_next = (2*COUNT_BITS)'(1);
                end
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                tb_a = idx_reg[PIXEL_BITS-1:0];
                if (sden_reg == '0 || rden_reg == '0 || lhs_reg >= rhs_reg
                    || ridx_reg == LV - 1'b1)
                begin
                    tb_we = 1'b1;
                    if (sden_reg == '0 || rden_reg == '0)
                        tb_wd = rmin_reg[PIXEL_BITS-1:0];
                    else if (lhs_reg >= rhs_reg)
                        tb_wd = ridx_reg[PIXEL_BITS-1:0];
                    else
                        tb_wd = last_reg;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LV - 1'b1)
                    begin
                        ready_tbl_next = 1'b1;
                        state_next = ST_MAP_RD;
                    end
                    else
                        state_next = ST_SCAN;
                end
                else
                begin
                    ridx_next = ridx_reg + 1'b1;
                    rh_a = pix_t'(ridx_reg + 1'b1);
                    rc_a = pix_t'(ridx_reg + 1'b1);
                    state_next = ST_MUL;
                end
            end
            ST_MAP_RD: state_next = ST_OUT;
            ST_OUT:
            begin
                out_next = 8'(tb_rd);
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_ch.valid        = ovalid_reg;
    assign out_ch.mapped_value = out_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_out_after_map: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> ovalid_reg) else $error("map result lost");
    a_tbl_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !ready_tbl_reg) else $error("table flag kept");
endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for histogram_specification_top
// Drives clear, count and map commands, predicts each mapped grey level from
// a local model of both histograms and the lookup table, and checks results.
// ----------------------------------------------------------------------------
module tb;
    import hsm_pkg::*;

    localparam int LIMIT = 10_000_000;

    logic clk;
    logic rst_n;

    hsm_in_if  in_ch ();
    hsm_out_if out_ch ();

    histogram_specification_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // local copy of the block state
    cnt_t       src_hist [LEVELS];
    cnt_t       ref_hist [LEVELS];
    cnt_t       src_total;
    cnt_t       ref_total;
    logic [7:0] lut [LEVELS];
    bit         lut_built;

    logic [7:0] expected_levels [$];
    int         errors;
    int         cycles;
    int         src_idle_pct;
    int         snk_idle_pct;
    int         hold_cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("** histogram_specification_top: FAILED **");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic cnt_t sat_inc(input cnt_t c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic void clear_hists();
        for (int i = 0; i < LEVELS; i++)
        begin
            src_hist[i] = '0;
            ref_hist[i] = '0;
        end
        src_total = '0;
        ref_total = '0;
        lut_built = 1'b0;
    endfunction

    function automatic void build_lut();
        int smin;
        int rmin;
        int last_ref;
        int pick;
        longint unsigned sden;
        longint unsigned rden;
        longint unsigned acc;
        longint unsigned scum;
        longint unsigned rcum [LEVELS];
        smin = LEVELS;
        rmin = LEVELS;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (src_hist[i] != 0) smin = i;
            if (ref_hist[i] != 0) rmin = i;
        end
        if (rmin >= LEVELS)
        begin
            for (int i = 0; i < LEVELS; i++) lut[i] = '0;
            return;
        end
        rden = (ref_total > ref_hist[rmin]) ? longint'(ref_total - ref_hist[rmin]) : 0;
        sden = (smin < LEVELS && src_total > src_hist[smin]) ?
               longint'(src_total - src_hist[smin]) : 0;
        acc = 0;
        last_ref = rmin;
        for (int r = 0; r < LEVELS; r++)
        begin
            if (r > rmin && ref_hist[r] != 0)
            begin
                acc += ref_hist[r];
                last_ref = r;
            end
            rcum[r] = (acc > rden) ? rden : acc;
        end
        acc = 0;
        for (int v = 0; v < LEVELS; v++)
        begin
            if (smin < LEVELS && v > smin) acc += src_hist[v];
            scum = (acc > sden) ? sden : acc;
            if (sden == 0 || rden == 0)
                pick = rmin;
            else
            begin
                pick = last_ref;
                for (int r = rmin; r < LEVELS; r++)
                begin
                    if (r != rmin && ref_hist[r] == 0) continue;
                    if (rcum[r] * sden >= scum * rden)
                    begin
                        pick = r;
                        break;
                    end
                end
            end
            lut[v] = pick[7:0];
        end
    endfunction

    function automatic void predict(input cmd_t cmd, input pix_t pix);
        case (cmd)
            CMD_CLEAR: clear_hists();
            CMD_SRC:
            begin
                src_hist[pix] = sat_inc(src_hist[pix]);
                src_total     = sat_inc(src_total);
            end
            CMD_REF:
            begin
                ref_hist[pix] = sat_inc(ref_hist[pix]);
                ref_total     = sat_inc(ref_total);
            end
            default:
            begin
                if (!lut_built)
                begin
                    build_lut();
                    lut_built = 1'b1;
                end
                expected_levels.push_back(lut[pix]);
            end
        endcase
    endfunction

    // one transfer on the input channel; inputs change on the falling edge
    task automatic send(input cmd_t cmd, input pix_t pix);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.command     = cmd;
        in_ch.pixel_value = pix;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict(cmd, pix);
        @(negedge clk);
    endtask

    // receiver: hold off for a stretch when asked, else stall at random
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready = 1'b0;
            hold_cycles--;
        end
        else
            out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_levels.size() == 0)
                report($sformatf("unexpected result %0d", out_ch.mapped_value));
            else
            begin
                logic [7:0] want;
                want = expected_levels.pop_front();
                if (out_ch.mapped_value !== want)
                    report($sformatf("mapped_value %0d, expected %0d",
                                     out_ch.mapped_value, want));
            end
        end
    end

    // grey level drawn from one of several shapes of distribution
    function automatic pix_t gen_pix(input int shape, input int base, input int span);
        case (shape)
            0: return pix_t'($urandom_range(255));
            1: return pix_t'((base + $urandom_range(span)) % LEVELS);
            2: return pix_t'(base);
            default: return pix_t'(($urandom_range(1) != 0) ? base : 255 - base);
        endcase
    endfunction

    task automatic test_unbuilt_and_empty();
        send(CMD_MAP, 8'd0);
        send(CMD_MAP, 8'd255);
        send(CMD_CLEAR, 8'd0);
        send(CMD_SRC, 8'd17);
        send(CMD_MAP, 8'd17);
        send(CMD_MAP, 8'hAA);
    endtask

    task automatic test_extremes();
        send(CMD_CLEAR, 8'hFF);
        send(CMD_SRC, 8'd0);
        send(CMD_SRC, 8'd255);
        send(CMD_REF, 8'd255);
        send(CMD_MAP, 8'd0);
        send(CMD_MAP, 8'd255);
        // count after a built table: table is kept
        send(CMD_REF, 8'd0);
        send(CMD_MAP, 8'd255);
        send(CMD_CLEAR, 8'd0);
        send(CMD_SRC, 8'd0);
        send(CMD_SRC, 8'd128);
        send(CMD_SRC, 8'd255);
        send(CMD_REF, 8'd10);
        send(CMD_REF, 8'd20);
        send(CMD_REF, 8'd30);
        send(CMD_MAP, 8'd0);
        send(CMD_MAP, 8'd128);
        send(CMD_MAP, 8'd255);
        send(CMD_MAP, 8'h55);
    endtask

    task automatic test_random_bands(input int bands);
        int sshape;
        int rshape;
        int sbase;
        int rbase;
        int n;
        for (int b = 0; b < bands; b++)
        begin
            sshape = $urandom_range(3);
            rshape = $urandom_range(3);
            sbase  = $urandom_range(255);
            rbase  = $urandom_range(255);
            send(CMD_CLEAR, pix_t'($urandom_range(255)));
            n = $urandom_range(1, 60);
            for (int i = 0; i < n; i++)
                send(CMD_SRC, gen_pix(sshape, sbase, 40));
            n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 60);
            for (int i = 0; i < n; i++)
                send(CMD_REF, gen_pix(rshape, rbase, 40));
            n = $urandom_range(20, 50);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    send(cmd_t'($urandom_range(1, 2)), pix_t'($urandom_range(255)));
                else
                    send(CMD_MAP, ($urandom_range(1) != 0) ?
                         gen_pix(sshape, sbase, 40) : pix_t'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_output_hold_off();
        hold_cycles = 400;
        for (int i = 0; i < 30; i++)
            send(CMD_MAP, pix_t'($urandom_range(255)));
    endtask

    task automatic drain();
        while (expected_levels.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        errors            = 0;
        cycles            = 0;
        hold_cycles       = 0;
        src_idle_pct      = 0;
        snk_idle_pct      = 0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_CLEAR;
        in_ch.pixel_value = '0;
        out_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        clear_hists();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 25;
        snk_idle_pct = 62;
        test_unbuilt_and_empty();
        test_extremes();
        test_random_bands(4);
        test_output_hold_off();
        src_idle_pct = 62;
        snk_idle_pct = 25;
        test_random_bands(4);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_bands(4);
        in_ch.valid = 1'b0;
        drain();

        if (errors == 0)
            $display("** histogram_specification_top: PASSED **");
        else
            $display("** histogram_specification_top: FAILED **");
        $finish;
    end
endmodule
